// ===== design/dbms_pkg.sv =====
// Shared types and constants of the depth block motion search unit.
// No dependencies; used by the top level and the testbench.
package dbms_pkg;

    localparam int DEF_MAX_SIZE   = 64;
    localparam int DEF_MAX_GRID   = 8;
    localparam int DEF_MAX_RADIUS = 7;

    localparam int IMG_W  = 7;
    localparam int GRID_W = 4;
    localparam int RAD_W  = 3;
    localparam int CFG_W  = 7;
    localparam int PIX_W  = 16;
    localparam int SAD_W  = 20;    // nine 16-bit differences
    localparam int CONF_W = 16;

    localparam int          MOTION_WEIGHT = 147;
    localparam int          CONF_DIVISOR  = 70779;
    // SAD at or above this drives the confidence to zero
    localparam int          CONF_SAT_SAD  = 70778;
    localparam logic [31:0] CONF_RECIP    = 32'((64'd1 << 48) / 64'(CONF_DIVISOR));
    localparam int          CONF_MAX      = 65535;

    typedef enum logic [1:0] {
        REG_IMAGE_SIZE    = 2'd0,
        REG_GRID_SIZE     = 2'd1,
        REG_SEARCH_RADIUS = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_LOAD,
        S_GRID,
        S_GRIDW,
        S_CELL,
        S_CAND,
        S_SAD,
        S_SCORE,
        S_CONF1,
        S_CONF2,
        S_MSTART,
        S_MEAN,
        S_EMIT
    } state_t;

    // Row and column offset (0..2) of a 3x3 tap
    function automatic logic [1:0] tap_row(input logic [3:0] t);
        logic [1:0] r;
        unique case (t)
            4'd0, 4'd1, 4'd2: r = 2'd0;
            4'd3, 4'd4, 4'd5: r = 2'd1;
            default:          r = 2'd2;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] tap_col(input logic [3:0] t);
        logic [1:0] c;
        unique case (t)
            4'd0, 4'd3, 4'd6: c = 2'd0;
            4'd1, 4'd4, 4'd7: c = 2'd1;
            default:          c = 2'd2;
        endcase
        return c;
    endfunction

endpackage

// ===== design/dbms_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module dbms_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dbms_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; shared for the cell pitch and the mean confidence.
module dbms_div #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] numer,
    input  logic [DEN_W-1:0] denom,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        if (start) begin
            quo_next  = numer;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(shifted - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = DEN_W'(shifted);
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start) begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== design/depth_block_motion_search_unit.sv =====
// Top level of the depth block motion search unit.
// Depends on dbms_pkg, dbms_ram and dbms_div.
//
//  - s_ channel: one request per pixel pair, raster order. tdata holds the
//    current pixel in [15:0] and the previous pixel in [31:16]. While frames
//    load the block takes one pair per cycle; both pixels go to two frame RAMs.
//  - After n*n pairs, n being image_size held to 8..MAX_SIZE, it stops
//    taking input and searches. Per cell it walks all displacements in the
//    radius; an in-frame candidate takes a candidate check, 9 RAM reads,
//    the registered read and scoring, an out-of-frame one the check alone.
//    Cell overhead is the centre, confidence and emit steps plus the wait
//    for the result register; the pitch check and the last cell's mean use
//    the divider. Each frame RAM has a single read port, one 3x3 tap per cycle.
//  - m_ channel: one request per cell in cell order; tlast marks the final
//    one, which also carries the mean confidence. A bad grid gives a single
//    request with tuser high.
//  - The result sits in one output register; while the receiver stalls the
//    search halts in front of it. Loading of the next frame starts as soon
//    as the last result is in that register.
//  - Reset (synchronous, active low) empties the output, clears the pixel
//    count and restores the register defaults. Frame RAMs are not cleared.
//  - Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
module depth_block_motion_search_unit
    import dbms_pkg::*;
#(
    parameter int MAX_SIZE   = DEF_MAX_SIZE,
    parameter int MAX_GRID   = DEF_MAX_GRID,
    parameter int MAX_RADIUS = DEF_MAX_RADIUS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // current_sample, previous_sample
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // cell_index, motion_dx, motion_dy,
                                   // confidence, mean_confidence, zero pad
    output logic        m_tuser,   // bad_config
    output logic        m_tlast    // last_result
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = NW + 4;
    localparam int RW    = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
    localparam int DW    = RW + 1;
    localparam int GIW   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
    localparam int CIW   = (MAX_GRID > 1) ? $clog2(MAX_GRID * MAX_GRID) : 1;
    localparam int GGW   = $clog2(MAX_GRID * MAX_GRID + 1);
    localparam int TW    = $clog2(MAX_GRID * MAX_GRID * CONF_MAX + 1);
    localparam int SCW   = $clog2(9 * CONF_MAX + MOTION_WEIGHT * 2 * MAX_RADIUS * MAX_RADIUS + 1);
    localparam int SQW   = 2 * DW + 1;

    // configuration
    logic [IMG_W-1:0]  img_reg;
    logic [GRID_W-1:0] grid_reg;
    logic [RAD_W-1:0]  rad_reg;

    state_t state_reg, state_next;

    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   step_reg, step_next;
    logic [GIW-1:0]  gy_reg, gy_next, gx_reg, gx_next;
    logic [CIW-1:0]  cidx_reg, cidx_next;
    logic [NW-1:0]   cy_reg, cy_next, cx_reg, cx_next;
    logic [NW-1:0]   py_reg, py_next, px_reg, px_next;
    logic signed [DW-1:0] dy_reg, dy_next, dx_reg, dx_next;
    logic signed [DW-1:0] bdy_reg, bdy_next, bdx_reg, bdx_next;
    logic [3:0]      tap_reg, tap_next;
    logic            rdv_reg, rdv_next;
    logic [SAD_W-1:0] acc_reg, acc_next;
    logic            found_reg, found_next;
    logic [SCW-1:0]  best_reg, best_next;
    logic [SAD_W-1:0] bsad_reg, bsad_next;
    logic [16:0]     qest_reg, qest_next;
    logic [CONF_W-1:0] conf_reg, conf_next;
    logic [CONF_W-1:0] mean_reg, mean_next;
    logic [TW-1:0]   total_reg, total_next;
    logic            bad_reg, bad_next;

    logic            m_valid_reg, m_valid_next;
    logic [47:0]     m_data_reg, m_data_next;
    logic            m_user_reg, m_user_next, m_last_reg, m_last_next;

    // effective sizes
    logic [NW-1:0]   n_eff, n_m2;
    logic [2*NW-1:0] nn;
    logic [RW-1:0]   r_eff;
    logic signed [DW-1:0] r_s;

    always_comb begin
        if (img_reg < IMG_W'(8)) begin
            n_eff = NW'(8);
        end else if (int'(img_reg) > MAX_SIZE) begin
            n_eff = NW'(MAX_SIZE);
        end else begin
            n_eff = NW'(img_reg);
        end
        n_m2  = n_eff - NW'(2);
        nn    = (2*NW)'(n_eff) * (2*NW)'(n_eff);
        r_eff = (int'(rad_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(rad_reg);
        r_s   = $signed({1'b0, r_eff});
    end

    // frame RAMs
    logic            in_acc;
    logic [AW-1:0]   raddr_cur, raddr_prev;
    logic [PIX_W-1:0] rd_cur, rd_prev;
    logic [NW-1:0]   row_c, col_c, row_p, col_p;

    assign in_acc = s_tvalid && s_tready;

    always_comb begin
        row_c = cy_reg + NW'(tap_row(tap_reg)) - NW'(1);
        col_c = cx_reg + NW'(tap_col(tap_reg)) - NW'(1);
        row_p = py_reg + NW'(tap_row(tap_reg)) - NW'(1);
        col_p = px_reg + NW'(tap_col(tap_reg)) - NW'(1);
        raddr_cur  = AW'((2*NW)'(row_c) * (2*NW)'(n_eff) + (2*NW)'(col_c));
        raddr_prev = AW'((2*NW)'(row_p) * (2*NW)'(n_eff) + (2*NW)'(col_p));
    end

    dbms_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_cur_ram (
        .aclk  (aclk),
        .we    (in_acc),
        .waddr (cnt_reg),
        .wdata (s_tdata[15:0]),
        .raddr (raddr_cur),
        .rdata (rd_cur)
    );

    dbms_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_prev_ram (
        .aclk  (aclk),
        .we    (in_acc),
        .waddr (cnt_reg),
        .wdata (s_tdata[31:16]),
        .raddr (raddr_prev),
        .rdata (rd_prev)
    );

    // shared divider: cell pitch n/g, then mean total/g^2
    logic            div_start, div_done;
    logic [TW-1:0]   div_num, div_quo;
    logic [GGW-1:0]  div_den, div_rem;

    always_comb begin
        if (state_reg == S_GRID) begin
            div_num = TW'(n_eff);
            div_den = GGW'(grid_reg);
        end else begin
            div_num = total_reg;
            div_den = GGW'(GGW'(grid_reg) * GGW'(grid_reg));
        end
    end

    dbms_div #(.NUM_W(TW), .DEN_W(GGW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .numer   (div_num),
        .denom   (div_den),
        .done    (div_done),
        .quot    (div_quo),
        .rem     (div_rem)
    );

    // datapath helpers
    logic [CW-1:0]   cen_y, cen_x;
    logic signed [NW+1:0] pys, pxs, one_s, nm2_s;
    logic            cand_ok;
    logic [PIX_W-1:0] adiff;
    logic signed [2*DW-1:0] sqx, sqy;
    logic [SQW-1:0]  dsq;
    logic [SCW-1:0]  score;
    logic [51:0]     qprod;
    logic [36:0]     qrem;
    logic [16:0]     qfix;
    logic            last_cell;
    logic            out_free;

    always_comb begin
        cen_y = CW'(step_reg >> 1) + CW'(gy_reg) * CW'(step_reg);
        cen_x = CW'(step_reg >> 1) + CW'(gx_reg) * CW'(step_reg);
        if (cen_y > CW'(n_m2)) cen_y = CW'(n_m2);
        if (cen_y < CW'(1))    cen_y = CW'(1);
        if (cen_x > CW'(n_m2)) cen_x = CW'(n_m2);
        if (cen_x < CW'(1))    cen_x = CW'(1);

        one_s   = (NW+2)'(1);
        nm2_s   = $signed({2'b00, n_m2});
        pys     = $signed({2'b00, cy_reg}) + (NW+2)'(dy_reg);
        pxs     = $signed({2'b00, cx_reg}) + (NW+2)'(dx_reg);
        cand_ok = (pys >= one_s) && (pys <= nm2_s) && (pxs >= one_s) && (pxs <= nm2_s);

        adiff = (rd_cur > rd_prev) ? rd_cur - rd_prev : rd_prev - rd_cur;

        sqx   = dx_reg * dx_reg;
        sqy   = dy_reg * dy_reg;
        dsq   = SQW'($unsigned(sqx)) + SQW'($unsigned(sqy));
        score = SCW'(acc_reg) + SCW'(SCW'(MOTION_WEIGHT) * SCW'(dsq));

        qprod = 52'(bsad_reg) * 52'(CONF_RECIP);
        qrem  = {1'b0, bsad_reg, 16'd0} - 37'(qest_reg) * 37'(CONF_DIVISOR);
        qfix  = (qrem >= 37'(CONF_DIVISOR)) ? qest_reg + 17'd1 : qest_reg;

        last_cell = (GRID_W'(gy_reg) == grid_reg - GRID_W'(1))
                 && (GRID_W'(gx_reg) == grid_reg - GRID_W'(1));
        out_free  = !m_valid_reg || m_tready;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        step_next  = step_reg;
        gy_next    = gy_reg;
        gx_next    = gx_reg;
        cidx_next  = cidx_reg;
        cy_next    = cy_reg;
        cx_next    = cx_reg;
        py_next    = py_reg;
        px_next    = px_reg;
        dy_next    = dy_reg;
        dx_next    = dx_reg;
        bdy_next   = bdy_reg;
        bdx_next   = bdx_reg;
        tap_next   = tap_reg;
        rdv_next   = 1'b0;
        acc_next   = acc_reg;
        found_next = found_reg;
        best_next  = best_reg;
        bsad_next  = bsad_reg;
        qest_next  = qest_reg;
        conf_next  = conf_reg;
        mean_next  = mean_reg;
        total_next = total_reg;
        bad_next   = bad_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        m_last_next  = m_last_reg;
        div_start  = 1'b0;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_LOAD: begin
                s_tready = 1'b1;
                if (in_acc) begin
                    if ((2*NW)'(cnt_reg) + (2*NW)'(1) >= nn) begin
                        cnt_next   = '0;
                        state_next = S_GRID;
                    end else begin
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            S_GRID: begin
                if (grid_reg == '0 || int'(grid_reg) > MAX_GRID) begin
                    bad_next   = 1'b1;
                    state_next = S_EMIT;
                end else begin
                    bad_next   = 1'b0;
                    div_start  = 1'b1;
                    state_next = S_GRIDW;
                end
            end
            S_GRIDW: begin
                if (div_done) begin
                    if (div_rem != '0) begin
                        bad_next   = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        step_next  = NW'(div_quo);
                        gy_next    = '0;
                        gx_next    = '0;
                        cidx_next  = '0;
                        total_next = '0;
                        state_next = S_CELL;
                    end
                end
            end
            S_CELL: begin
                cy_next    = NW'(cen_y);
                cx_next    = NW'(cen_x);
                dy_next    = -r_s;
                dx_next    = -r_s;
                found_next = 1'b0;
                state_next = S_CAND;
            end
            S_CAND, S_SCORE: begin
                if (state_reg == S_CAND && cand_ok) begin
                    py_next    = NW'(pys);
                    px_next    = NW'(pxs);
                    tap_next   = '0;
                    acc_next   = '0;
                    state_next = S_SAD;
                end else begin
                    if (state_reg == S_SCORE && (!found_reg || score < best_reg)) begin
                        found_next = 1'b1;
                        best_next  = score;
                        bsad_next  = acc_reg;
                        bdx_next   = dx_reg;
                        bdy_next   = dy_reg;
                    end
                    // next candidate, dx inner
                    if (dx_reg < r_s) begin
                        dx_next    = dx_reg + DW'(1);
                        state_next = S_CAND;
                    end else if (dy_reg < r_s) begin
                        dy_next    = dy_reg + DW'(1);
                        dx_next    = -r_s;
                        state_next = S_CAND;
                    end else begin
                        state_next = S_CONF1;
                    end
                end
            end
            S_SAD: begin
                if (rdv_reg) begin
                    acc_next = acc_reg + SAD_W'(adiff);
                end
                if (tap_reg < 4'd9) begin
                    tap_next = tap_reg + 4'd1;
                    rdv_next = 1'b1;
                end else begin
                    state_next = S_SCORE;
                end
            end
            S_CONF1: begin
                qest_next  = 17'(qprod >> 32);
                state_next = S_CONF2;
            end
            S_CONF2: begin
                if (!found_reg || bsad_reg >= SAD_W'(CONF_SAT_SAD)) begin
                    conf_next  = '0;
                    total_next = total_reg;
                end else begin
                    conf_next  = CONF_W'(17'(CONF_MAX) - qfix);
                    total_next = total_reg + TW'(CONF_W'(17'(CONF_MAX) - qfix));
                end
                state_next = last_cell ? S_MSTART : S_EMIT;
            end
            S_MSTART: begin
                div_start  = 1'b1;
                state_next = S_MEAN;
            end
            S_MEAN: begin
                if (div_done) begin
                    mean_next  = CONF_W'(div_quo);
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (bad_reg) begin
                        m_data_next = '0;
                        m_user_next = 1'b1;
                        m_last_next = 1'b1;
                        state_next  = S_LOAD;
                    end else begin
                        m_user_next = 1'b0;
                        m_last_next = last_cell;
                        m_data_next = {2'b00,
                                       last_cell ? mean_reg : CONF_W'(0),
                                       conf_reg,
                                       4'(32'(found_reg ? bdy_reg : DW'(0))),
                                       4'(32'(found_reg ? bdx_reg : DW'(0))),
                                       6'(cidx_reg)};
                        if (last_cell) begin
                            state_next = S_LOAD;
                        end else begin
                            cidx_next = cidx_reg + CIW'(1);
                            if (GRID_W'(gx_reg) == grid_reg - GRID_W'(1)) begin
                                gx_next = '0;
                                gy_next = gy_reg + GIW'(1);
                            end else begin
                                gx_next = gx_reg + GIW'(1);
                            end
                            state_next = S_CELL;
                        end
                    end
                end
            end
            default: state_next = S_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            rdv_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            img_reg     <= IMG_W'(64);
            grid_reg    <= GRID_W'(8);
            rad_reg     <= RAD_W'(2);
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rdv_reg     <= rdv_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_addr))
                    REG_IMAGE_SIZE:    img_reg  <= cfg_wdata;
                    REG_GRID_SIZE:     grid_reg <= GRID_W'(cfg_wdata);
                    REG_SEARCH_RADIUS: rad_reg  <= RAD_W'(cfg_wdata);
                    default: ;
                endcase
            end
        end
        step_reg   <= step_next;
        gy_reg     <= gy_next;
        gx_reg     <= gx_next;
        cidx_reg   <= cidx_next;
        cy_reg     <= cy_next;
        cx_reg     <= cx_next;
        py_reg     <= py_next;
        px_reg     <= px_next;
        dy_reg     <= dy_next;
        dx_reg     <= dx_next;
        bdy_reg    <= bdy_next;
        bdx_reg    <= bdx_next;
        tap_reg    <= tap_next;
        acc_reg    <= acc_next;
        found_reg  <= found_next;
        best_reg   <= best_next;
        bsad_reg   <= bsad_next;
        qest_reg   <= qest_next;
        conf_reg   <= conf_next;
        mean_reg   <= mean_next;
        total_reg  <= total_next;
        bad_reg    <= bad_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // RAM read data only returns while a patch is being summed
    a_rdv_in_sad: assert property (@(posedge aclk) disable iff (!aresetn)
        rdv_reg |-> state_reg == S_SAD)
        else $error("read data valid outside SAD accumulation");

    a_bad_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("bad grid result not marked last");

    a_mean_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tdata[45:30] == 16'd0)
        else $error("mean confidence on a non-final result");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_GRIDW || state_reg == S_MEAN))
        else $error("divider finished with no consumer waiting");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of depth_block_motion_search_unit.
// Holds a scoreboard class with its own motion search predictor; needs only the RTL
// and dbms_pkg.
module testbench;
    import dbms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DEPTH = DEF_MAX_SIZE * DEF_MAX_SIZE;
    localparam int IDLE_LIMIT  = 40000;   // worst cell: 225 candidates plus stalls
    localparam int TOTAL_ITEMS = 280;

    // pixel content of a frame
    localparam int PIX_RANDOM   = 0;
    localparam int PIX_EXTREME  = 1;
    localparam int PIX_SHIFTED  = 2;
    localparam int PIX_OPPOSITE = 3;

    typedef struct packed {
        logic [5:0]  cell_idx;
        logic [3:0]  dx;
        logic [3:0]  dy;
        logic [15:0] conf;
        logic [15:0] mean;
        logic        bad;
        logic        last;
    } motion_result_t;

    // Predicts the per-cell motion results and checks them in order.
    class motion_scoreboard;
        int unsigned    image_size, grid_size, search_radius;
        logic [15:0]    cur_px [FRAME_DEPTH];
        logic [15:0]    prev_px[FRAME_DEPTH];
        int unsigned    pixel_count;
        motion_result_t pending[$];
        int             errors;

        function void reset_state();
            image_size = 64; grid_size = 8; search_radius = 2;
            pixel_count = 0; pending.delete(); errors = 0;
        endfunction

        function int unsigned frame_side();
            if (image_size < 8) return 8;
            if (image_size > DEF_MAX_SIZE) return DEF_MAX_SIZE;
            return image_size;
        endfunction

        function void set_reg(cfg_reg_t r, int unsigned v);
            case (r)
                REG_IMAGE_SIZE:    image_size    = v & 'h7F;
                REG_GRID_SIZE:     grid_size     = v & 'hF;
                REG_SEARCH_RADIUS: search_radius = v & 'h7;
                default: ;
            endcase
        endfunction

        function int centre(int c, int n);
            if (c > n - 2) c = n - 2;
            if (c < 1) c = 1;
            return c;
        endfunction

        function void note_pixel(logic [15:0] cur, logic [15:0] prev);
            int n;
            n = frame_side();
            cur_px[pixel_count % FRAME_DEPTH]  = cur;
            prev_px[pixel_count % FRAME_DEPTH] = prev;
            pixel_count++;
            if (pixel_count >= n * n) begin
                pixel_count = 0;
                search_frame(n);
            end
        endfunction

        function void search_frame(int n);
            int g, r, stp, cx, cy, px, py, bdx, bdy;
            int unsigned sad, score, best_score, best_sad, conf, total;
            longint unsigned drop;
            bit found;
            motion_result_t res;
            g = grid_size;
            r = search_radius;
            res = '0;
            if (g == 0 || g > DEF_MAX_GRID || (n % g) != 0) begin
                res.bad = 1; res.last = 1;
                pending.push_back(res);
                return;
            end
            stp = n / g;
            total = 0;
            for (int gy = 0; gy < g; gy++) begin
                cy = centre(stp / 2 + gy * stp, n);
                for (int gx = 0; gx < g; gx++) begin
                    cx = centre(stp / 2 + gx * stp, n);
                    found = 0; best_score = 0; best_sad = 0; bdx = 0; bdy = 0;
                    for (int dy = -r; dy <= r; dy++) begin
                        py = cy + dy;
                        if (py < 1 || py + 1 >= n) continue;
                        for (int dx = -r; dx <= r; dx++) begin
                            px = cx + dx;
                            if (px < 1 || px + 1 >= n) continue;
                            sad = 0;
                            for (int yy = -1; yy <= 1; yy++)
                                for (int xx = -1; xx <= 1; xx++) begin
                                    int a, b;
                                    a = cur_px[(cy + yy) * n + cx + xx];
                                    b = prev_px[(py + yy) * n + px + xx];
                                    sad += (a > b) ? a - b : b - a;
                                end
                            score = sad + MOTION_WEIGHT * (dx * dx + dy * dy);
                            if (!found || score < best_score) begin
                                found = 1; best_score = score; best_sad = sad;
                                bdx = dx; bdy = dy;
                            end
                        end
                    end
                    conf = 0;
                    if (found) begin
                        drop = (longint'(best_sad) << 16) / CONF_DIVISOR;
                        conf = (drop >= 65535) ? 0 : 32'(65535 - drop);
                    end
                    total += conf;
                    res = '0;
                    res.cell_idx = 6'(gy * g + gx);
                    res.dx = bdx[3:0];
                    res.dy = bdy[3:0];
                    res.conf = conf[15:0];
                    pending.push_back(res);
                end
            end
            pending[$].mean = 16'(total / (g * g));
            pending[$].last = 1;
        endfunction

        function void check_result(logic [47:0] data, logic bad, logic last);
            motion_result_t want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: tdata=%h", data);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[5:0] !== want.cell_idx) begin
                $error("cell_index: expected %0d, got %0d", want.cell_idx, data[5:0]);
                errors++;
            end
            if (data[9:6] !== want.dx) begin
                $error("motion_dx: expected %0d, got %0d",
                       $signed(want.dx), $signed(data[9:6])); errors++;
            end
            if (data[13:10] !== want.dy) begin
                $error("motion_dy: expected %0d, got %0d",
                       $signed(want.dy), $signed(data[13:10])); errors++;
            end
            if (data[29:14] !== want.conf) begin
                $error("confidence: expected %0d, got %0d", want.conf, data[29:14]); errors++;
            end
            if (data[45:30] !== want.mean) begin
                $error("mean_confidence: expected %0d, got %0d", want.mean, data[45:30]);
                errors++;
            end
            if (bad !== want.bad) begin
                $error("bad_config: expected %0b, got %0b", want.bad, bad); errors++;
            end
            if (last !== want.last) begin
                $error("last_result: expected %0b, got %0b", want.last, last); errors++;
            end
        endfunction
    endclass

    logic             aclk = 0;
    logic             aresetn = 0;
    logic             cfg_we = 0;
    logic [1:0]       cfg_addr = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid = 0;
    logic             s_tready;
    logic [31:0]      s_tdata = '0;
    logic             m_tvalid;
    logic             m_tready = 0;
    logic [47:0]      m_tdata;
    logic             m_tuser;
    logic             m_tlast;

    motion_scoreboard sb;
    int burst_left;
    int sent_items;
    int idle_cycles;
    int stall_mode;
    int stall_timer;

    always begin
        #2 aclk = 1;
        #2 aclk = 0;
    end

    depth_block_motion_search_unit dut (
        .aclk, .aresetn, .cfg_we, .cfg_addr, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );

    // Receiver: stall pattern switches between always ready, coin flip and mostly
    // stalled. Result checking and the watchdog run on the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > IDLE_LIMIT) begin
                $display("testbench failed");
                $finish;
            end
        end
        if (stall_timer == 0) begin
            stall_mode  <= $urandom_range(0, 2);
            stall_timer <= $urandom_range(20, 300);
        end else begin
            stall_timer <= stall_timer - 1;
        end
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Register writes happen only once the expected queue has drained.
    // Write enable stays high across back to back writes; setup drops it.
    task automatic write_reg(cfg_reg_t r, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge aclk);
        sb.set_reg(r, v);
    endtask

    task automatic wait_idle();
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic setup(int unsigned img, int unsigned grid, int unsigned rad);
        wait_idle();
        write_reg(REG_IMAGE_SIZE, img);
        write_reg(REG_GRID_SIZE, grid);
        write_reg(REG_SEARCH_RADIUS, rad);
        cfg_we <= 1'b0;
    endtask

    // One pixel request; valid stays high across a burst.
    task automatic send_pixel(logic [15:0] cur, logic [15:0] prev);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {prev, cur};
        do @(posedge aclk); while (!s_tready);
        sb.note_pixel(cur, prev);
        burst_left--;
    endtask

    function automatic logic [15:0] texture(int x, int y);
        return 16'(x * x * 977 + y * 2311 + ((x ^ y) * 523) + x * y * 61);
    endfunction

    task automatic send_frame(int mode);
        int n, sx, sy;
        logic [15:0] c, p;
        n  = sb.frame_side();
        sx = $urandom_range(0, 6) - 3;
        sy = $urandom_range(0, 6) - 3;
        for (int y = 0; y < n; y++)
            for (int x = 0; x < n; x++) begin
                case (mode)
                    PIX_EXTREME: begin
                        c = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        p = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    end
                    PIX_SHIFTED: begin
                        // previous frame is the current one moved, plus a little noise
                        c = texture(x, y);
                        p = texture(x + sx, y + sy) + 16'($urandom_range(0, 40));
                    end
                    PIX_OPPOSITE: begin
                        c = 16'h0000;
                        p = 16'hFFFF;
                    end
                    default: begin
                        c = 16'($urandom);
                        p = 16'($urandom);
                    end
                endcase
                send_pixel(c, p);
            end
        s_tvalid <= 1'b0;
        burst_left = 0;
        sent_items += n * n;
    endtask

    initial begin
        int img, grid, rad;
        sb = new();
        sb.reset_state();
        burst_left = 0;
        sent_items = 0;
        idle_cycles = 0;
        stall_mode = 0;
        stall_timer = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: single cell with a saturated image size, full grid with the
        // widest search, and a grid that does not divide the frame
        setup(3, 1, 0);    send_frame(PIX_EXTREME);
        setup(8, 8, 7);    send_frame(PIX_SHIFTED);
        setup(8, 3, 2);    send_frame(PIX_RANDOM);

        // random: small frames, mostly with a dividing grid, some bad grids
        while (sent_items + 64 <= TOTAL_ITEMS) begin
            img  = $urandom_range(8, 9);
            grid = $urandom_range(1, 8);
            if ($urandom_range(0, 5) != 0)
                while (img % grid != 0) grid--;
            else if ($urandom_range(0, 1))
                grid = $urandom_range(0, 15);
            rad = $urandom_range(0, 7);
            setup(img, grid, rad);
            send_frame($urandom_range(PIX_RANDOM, PIX_OPPOSITE));
        end

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (sb.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule
